// File: hw/rtl/weight_stationary_matmul_defines.svh
// weight_stationary_matmul_defines.svh: assertion macros for the matmul block
// depends on: clk and rst being in scope where a macro is used
`ifndef WEIGHT_STATIONARY_MATMUL_DEFINES_SVH
`define WEIGHT_STATIONARY_MATMUL_DEFINES_SVH

// same-cycle property, disabled while in reset
`define WSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// antecedent this cycle, consequent on the next
`define WSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/wsm_pkg.sv
// wsm_pkg: sizes, register indexes and the queue entry type of the matmul block
// depends on: nothing
package wsm_pkg;

  localparam int MAX_K     = 16;
  localparam int MAX_N     = 16;
  localparam int ELEM_BITS = 32;

  localparam int DEPTH   = MAX_K * MAX_N;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int TOT_W   = $clog2(DEPTH + 1);
  localparam int KC_W    = $clog2(MAX_K);
  localparam int KK_W    = $clog2(MAX_K + 1);
  localparam int COL_W   = $clog2(MAX_N);
  localparam int CNT_W   = $clog2(MAX_N + 1);
  localparam int ROW_W   = 16;
  localparam int CFG_KN_W  = 5;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_K_DEPTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_N_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_M_ROWS  = 2'd2;

  localparam logic CMD_WEIGHT = 1'b0;
  localparam logic CMD_ACT    = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one classified item travelling from front to back
  typedef struct packed {
    logic                 is_act;
    logic [ELEM_BITS-1:0] elem;
    logic [ADDR_W-1:0]    addr;
    logic [CNT_W-1:0]     ncols;
    logic                 close_row;
    logic [ROW_W-1:0]     row;
    logic                 last_row;
  } wsm_entry_t;

endpackage

// File: hw/rtl/wsm_front.sv
// wsm_front: configuration registers, counters and item classification
// depends on: wsm_pkg
module wsm_front import wsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic                  cmd,
  input  logic signed [31:0]    elem_value,
  output wsm_entry_t            entry
);

  logic [CFG_KN_W-1:0] k_depth;
  logic [CFG_KN_W-1:0] n_cols;
  logic [ROW_W-1:0]    m_rows;

  logic [ADDR_W-1:0] weight_pointer;
  logic [KC_W-1:0]   inner_counter;
  logic [ROW_W-1:0]  row_counter;

  logic [ADDR_W-1:0] weight_pointer_next;
  logic [KC_W-1:0]   inner_counter_next;
  logic [ROW_W-1:0]  row_counter_next;

  logic [KK_W-1:0]   kk;
  logic [CNT_W-1:0]  nn;
  logic [ROW_W-1:0]  mm;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  wr_addr;
  logic [TOT_W-1:0]  wr_inc;
  logic [KC_W-1:0]   k_sel;
  logic              close_row;
  logic              last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_depth <= CFG_KN_W'(MAX_K);
      n_cols  <= CFG_KN_W'(MAX_N);
      m_rows  <= ROW_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_K_DEPTH: k_depth <= cfg_data[CFG_KN_W-1:0];
        CFG_N_COLS:  n_cols  <= cfg_data[CFG_KN_W-1:0];
        CFG_M_ROWS:  m_rows  <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the registers to their working ranges
  always_comb begin
    if (k_depth == '0) kk = KK_W'(1);
    else if (k_depth > CFG_KN_W'(MAX_K)) kk = KK_W'(MAX_K);
    else kk = KK_W'(k_depth);
    if (n_cols == '0) nn = CNT_W'(1);
    else if (n_cols > CFG_KN_W'(MAX_N)) nn = CNT_W'(MAX_N);
    else nn = CNT_W'(n_cols);
    mm = (m_rows == '0) ? ROW_W'(1) : m_rows;
  end

  always_comb begin
    total   = TOT_W'(kk * nn);
    wr_addr = (TOT_W'(weight_pointer) >= total) ? '0 : TOT_W'(weight_pointer);
    wr_inc  = wr_addr + TOT_W'(1);
    k_sel   = (KK_W'(inner_counter) >= kk) ? KC_W'(kk - KK_W'(1)) : inner_counter;
    close_row = (KK_W'(k_sel) + KK_W'(1)) >= kk;
    last_row  = row_counter >= (mm - ROW_W'(1));

    weight_pointer_next = weight_pointer;
    inner_counter_next  = inner_counter;
    row_counter_next    = row_counter;
    if (cmd == CMD_WEIGHT) begin
      weight_pointer_next = (wr_inc >= total) ? '0 : ADDR_W'(wr_inc);
      inner_counter_next  = '0;
      row_counter_next    = '0;
    end else if (close_row) begin
      inner_counter_next = '0;
      row_counter_next   = last_row ? '0 : row_counter + ROW_W'(1);
    end else begin
      inner_counter_next = k_sel + KC_W'(1);
    end

    entry.is_act    = (cmd == CMD_ACT);
    entry.elem      = elem_value[ELEM_BITS-1:0];
    entry.addr      = (cmd == CMD_WEIGHT) ? ADDR_W'(wr_addr) : ADDR_W'(k_sel * nn);
    entry.ncols     = nn;
    entry.close_row = close_row;
    entry.row       = row_counter;
    entry.last_row  = last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_pointer <= '0;
      inner_counter  <= '0;
      row_counter    <= '0;
    end else if (accept) begin
      weight_pointer <= weight_pointer_next;
      inner_counter  <= inner_counter_next;
      row_counter    <= row_counter_next;
    end
  end

endmodule

// File: hw/rtl/wsm_queue.sv
// wsm_queue: two-entry queue of classified items between front and back
// depends on: wsm_pkg, weight_stationary_matmul_defines.svh
`include "weight_stationary_matmul_defines.svh"
module wsm_queue import wsm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  wsm_entry_t push_entry,
  input  logic       pop,
  output wsm_entry_t head,
  output logic       not_empty,
  output logic       full
);

  wsm_entry_t        slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `WSM_ASSERT(a_pop_not_empty, (pop) |-> (count != '0), "pop from empty queue")
  `WSM_ASSERT(a_push_not_full, (push) |-> (count != QCNT_W'(QDEPTH)), "push into full queue")

endmodule

// File: hw/rtl/wsm_back.sv
// wsm_back: weight memory, shared multiply-accumulate over columns and result emission
// depends on: wsm_pkg, weight_stationary_matmul_defines.svh
`include "weight_stationary_matmul_defines.svh"
module wsm_back import wsm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  wsm_entry_t         head,
  input  logic               not_empty,
  output logic               pop,
  output logic               result_valid,
  output logic signed [31:0] result_value,
  output logic [COL_W-1:0]   col_index,
  output logic [ROW_W-1:0]   row_index,
  output logic               row_last,
  output logic               matrix_last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state;

  logic [ELEM_BITS-1:0] wmem [DEPTH];
  logic [ELEM_BITS-1:0] rdata;

  logic [ELEM_BITS-1:0] op_elem;
  logic [ADDR_W-1:0]    op_addr;
  logic [CNT_W-1:0]     op_ncols;
  logic                 op_close;
  logic [ROW_W-1:0]     op_row;
  logic                 op_last_row;

  logic [COL_W-1:0]     col_n;
  logic [COL_W-1:0]     rd_n;
  logic [COL_W-1:0]     mul_n;
  logic                 rd_v;
  logic                 mul_v;
  logic [ELEM_BITS-1:0] prod;

  logic [ELEM_BITS-1:0] sums [MAX_N];
  logic [MAX_N-1:0]     sum_valid;
  logic [COL_W-1:0]     sel_n;
  logic [ELEM_BITS-1:0] sum_rd;
  logic                 last_col;

  assign pop      = not_empty && (state == ST_IDLE);
  assign last_col = (CNT_W'(col_n) == (op_ncols - CNT_W'(1)));
  // accumulate and emission never overlap, so one read port serves both
  assign sel_n    = (state == ST_EMIT) ? col_n : mul_n;
  assign sum_rd   = sum_valid[sel_n] ? sums[sel_n] : '0;

  always_ff @(posedge clk) begin
    if (pop && !head.is_act) wmem[head.addr] <= head.elem;
    rdata <= wmem[op_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rd_v         <= 1'b0;
      mul_v        <= 1'b0;
      sum_valid    <= '0;
      result_valid <= 1'b0;
    end else begin
      rd_v         <= (state == ST_MAC);
      mul_v        <= rd_v;
      result_valid <= (state == ST_EMIT);
      if (mul_v) sum_valid[mul_n] <= 1'b1;
      case (state)
        ST_IDLE: begin
          if (pop) begin
            if (head.is_act) state <= ST_MAC;
            else sum_valid <= '0;
          end
        end
        ST_MAC: begin
          if (last_col) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!rd_v && !mul_v) state <= op_close ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (last_col) begin
            state     <= ST_IDLE;
            sum_valid <= '0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_elem     <= head.elem;
      op_addr     <= head.addr;
      op_ncols    <= head.ncols;
      op_close    <= head.close_row;
      op_row      <= head.row;
      op_last_row <= head.last_row;
      col_n       <= '0;
    end else if (state == ST_MAC) begin
      op_addr <= op_addr + ADDR_W'(1);
      col_n   <= col_n + COL_W'(1);
    end else if (state == ST_DRAIN) begin
      col_n <= '0;
    end else if (state == ST_EMIT) begin
      col_n <= col_n + COL_W'(1);
    end
    rd_n  <= col_n;
    mul_n <= rd_n;
    prod  <= op_elem * rdata;
    if (mul_v) sums[mul_n] <= sum_rd + prod;
    if (state == ST_EMIT) begin
      result_value <= 32'(signed'(sum_rd));
      col_index    <= col_n;
      row_index    <= op_row;
      row_last     <= last_col;
      matrix_last  <= last_col && op_last_row;
    end
  end

  `WSM_ASSERT(a_emit_drained, (state == ST_EMIT) |-> (!rd_v && !mul_v), "emit with mac in flight")
  `WSM_ASSERT_NEXT(a_emit_strobe, state == ST_EMIT, result_valid, "emission cycle without strobe")
  `WSM_ASSERT(a_last_flags, (result_valid && matrix_last) |-> (row_last), "matrix end off row end")

endmodule

// File: hw/rtl/weight_stationary_matmul.sv
// weight_stationary_matmul: top level of the integer matrix multiply C = A x B
// depends on: wsm_pkg, wsm_front, wsm_queue, wsm_back
//
// usage
//   input: an item transfers at a rising edge with start high and busy low;
//     cmd 0 loads the next weight of B (row-major), cmd 1 streams the next
//     element of A; a weight load also restarts the row and k counters
//   config: cfg_write, cfg_index, cfg_data write k_depth (0), n_cols (1) or
//     m_rows (2), one per write; other indexes are ignored; write only while idle
//   results: one per cycle with result_valid high, cannot be held off; a row
//     completion gives n_cols results in column order with row_last on the
//     final one and matrix_last on the final one of the last row
//   back end: a weight load is written into the weight memory as it leaves the
//     queue; an activation steps one column a cycle through the single weight
//     memory read port and the shared multiplier, then drains, and then emits
//     the results of the row when it closes a row
//   busy rises when the two-entry queue between front and back is full
//   reset: counters, queue and sums clear, registers return to 16, 16, 1;
//     the weight memory keeps its contents and must be loaded before use
module weight_stationary_matmul import wsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cmd,
  input  logic signed [31:0]    elem_value,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  result_valid,
  output logic signed [31:0]    result_value,
  output logic [COL_W-1:0]      col_index,
  output logic [ROW_W-1:0]      row_index,
  output logic                  row_last,
  output logic                  matrix_last
);

  // input transfer
  logic       accept;
  wsm_entry_t entry;
  // queue handshake with the back end
  wsm_entry_t head;
  logic       not_empty;
  logic       pop;
  logic       full;

  assign accept = start && !busy;
  assign busy   = full;

  // classifies the item and moves the pointer and counters at transfer time
  wsm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .cmd        (cmd),
    .elem_value (elem_value),
    .entry      (entry)
  );

  // decouples the front from the multi-cycle back end
  wsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .full       (full)
  );

  // weight memory, column accumulation and result emission
  wsm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .not_empty    (not_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_value (result_value),
    .col_index    (col_index),
    .row_index    (row_index),
    .row_last     (row_last),
    .matrix_last  (matrix_last)
  );

endmodule
